// ===== design/packet_verdict_with_timed_blocklist_assert.svh =====
// Assertion macros for the packet verdict block.
`ifndef PACKET_VERDICT_WITH_TIMED_BLOCKLIST_ASSERT_SVH
`define PACKET_VERDICT_WITH_TIMED_BLOCKLIST_ASSERT_SVH
`ifndef ASSERT_OFF
`define PVTB_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define PVTB_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define PVTB_ASSERT_IMPLY(label, clk, rst, a, b)
`define PVTB_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== design/pvtb_pkg.sv =====
package pvtb_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [15:0] DEFAULT_BLOCK_SECONDS = 16'd300;
  localparam logic [9:0] MS_PER_SECOND = 10'd1000;
  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    MODE_PACKET  = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_BLOCK   = 2'd2,
    MODE_UNBLOCK = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_ALERT  = 2'd0,
    ACT_LOG    = 2'd1,
    ACT_DROP   = 2'd2,
    ACT_REJECT = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    V_PASS_DISABLED = 4'd0,
    V_PASS_CLEAN    = 4'd1,
    V_DROP_BLOCKED  = 4'd2,
    V_DROP_SIG      = 4'd3,
    V_REJECT_SIG    = 4'd4,
    V_PASS_LOGGED   = 4'd5,
    V_PASS_ALERTED  = 4'd6,
    V_DONE          = 4'd7,
    V_ZERO_ADDR     = 4'd8
  } verdict_t;

  typedef enum logic [2:0] {
    REG_ENABLED         = 3'd0,
    REG_ACTION_LOW      = 3'd1,
    REG_ACTION_MEDIUM   = 3'd2,
    REG_ACTION_HIGH     = 3'd3,
    REG_ACTION_CRITICAL = 3'd4,
    REG_AUTO_BLOCK      = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] source_ip;
    logic        has_source;
    logic        sig_matched;
    logic [1:0]  sig_severity;
    logic [15:0] block_seconds;
  } item_t;

  typedef struct packed {
    logic              enabled;
    logic [3:0][1:0]   action;
    logic [15:0]       auto_block_seconds;
  } cfg_t;

  typedef struct packed {
    logic        drop;
    logic [3:0]  verdict;
    logic        table_full;
  } result_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] start_ms;
    logic [15:0] seconds;
  } entry_t;

endpackage

// ===== design/pvtb_mem.sv =====
module pvtb_mem (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [pvtb_pkg::IDX_W-1:0] wr_idx,
  input  pvtb_pkg::entry_t         wr_data,
  input  logic                     rd_en,
  input  logic [pvtb_pkg::IDX_W-1:0] rd_idx,
  output pvtb_pkg::entry_t         rd_data
);
  import pvtb_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

// ===== design/pvtb_core.sv =====
module pvtb_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pvtb_pkg::item_t   item,
  input  pvtb_pkg::cfg_t    cfg,
  output logic              res_valid,
  input  logic              res_ready,
  output pvtb_pkg::result_t res
);
  import pvtb_pkg::*;

  state_t state, state_next;
  item_t cur;
  logic [31:0] now_ms;
  logic [TABLE_ENTRIES-1:0] valid, valid_next;

  logic [CNT_W-1:0] iss;
  logic cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic found, have_free;
  logic [IDX_W-1:0] fidx, free_idx;
  logic [31:0] fstart;
  logic [15:0] fsecs;
  logic [31:0] age;
  logic [25:0] limit;

  entry_t rd_data, wr_data;
  logic rd_en, wr_en;
  logic [IDX_W-1:0] wr_idx;

  logic scan_last;
  logic fire;

  pvtb_mem u_mem (
    .clk(clk), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
    .rd_en(rd_en), .rd_idx(iss[IDX_W-1:0]), .rd_data(rd_data)
  );

  assign in_ready = (state == S_IDLE);
  assign rd_en = (state == S_SCAN) && (iss != CNT_W'(TABLE_ENTRIES));
  assign scan_last = (state == S_SCAN) && (iss == CNT_W'(TABLE_ENTRIES)) && cmp_vld;
  assign fire = (state == S_DECIDE) && res_ready;
  assign res_valid = (state == S_DECIDE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (mode_t'(item.mode) == MODE_TICK) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN:   if (scan_last) state_next = S_CALC;
      S_CALC:   state_next = S_DECIDE;
      S_DECIDE: if (res_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan: one read issued per cycle, compared the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      iss <= '0;
      cmp_vld <= 1'b0;
      found <= 1'b0;
      have_free <= 1'b0;
    end else if (state == S_IDLE) begin
      iss <= '0;
      cmp_vld <= 1'b0;
      found <= 1'b0;
      have_free <= 1'b0;
    end else if (state == S_SCAN) begin
      cmp_vld <= rd_en;
      cmp_idx <= iss[IDX_W-1:0];
      if (rd_en) begin
        iss <= iss + CNT_W'(1);
      end
      if (cmp_vld) begin
        if (valid[cmp_idx] && rd_data.addr == cur.source_ip && !found) begin
          found <= 1'b1;
          fidx <= cmp_idx;
          fstart <= rd_data.start_ms;
          fsecs <= rd_data.seconds;
        end
        if (!valid[cmp_idx] && !have_free) begin
          have_free <= 1'b1;
          free_idx <= cmp_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur <= item;
    end
    if (state == S_CALC) begin
      age <= now_ms - fstart;
      limit <= 26'(fsecs) * 26'(MS_PER_SECOND);
    end
  end

  logic src_ok, expired, do_clr, do_ins, slot_ok, full;
  logic [IDX_W-1:0] slot;
  logic [15:0] ins_secs;
  action_t act;

  always_comb begin
    res = '0;
    res.verdict = V_DONE;
    do_clr = 1'b0;
    do_ins = 1'b0;
    full = 1'b0;
    slot = free_idx;
    slot_ok = have_free;
    ins_secs = cur.block_seconds;
    src_ok = cur.has_source && (cur.source_ip != 32'd0);
    expired = age > {6'd0, limit};
    act = action_t'(cfg.action[cur.sig_severity]);
    unique case (mode_t'(cur.mode))
      MODE_PACKET: begin
        if (!cfg.enabled) begin
          res.verdict = V_PASS_DISABLED;
        end else if (src_ok && found && !expired) begin
          res.drop = 1'b1;
          res.verdict = V_DROP_BLOCKED;
        end else begin
          do_clr = src_ok && found;
          // An aged entry freed just now may be the lowest free slot.
          if (do_clr && (!have_free || fidx < free_idx)) begin
            slot = fidx;
            slot_ok = 1'b1;
          end
          ins_secs = cfg.auto_block_seconds;
          if (!cur.sig_matched) begin
            res.verdict = V_PASS_CLEAN;
          end else begin
            case (act) inside
              ACT_DROP, ACT_REJECT: begin
                res.drop = 1'b1;
                res.verdict = (act == ACT_DROP) ? V_DROP_SIG : V_REJECT_SIG;
                if (src_ok) begin
                  do_ins = slot_ok;
                  full = !slot_ok;
                end
              end
              ACT_LOG: res.verdict = V_PASS_LOGGED;
              default: res.verdict = V_PASS_ALERTED;
            endcase
          end
        end
      end
      MODE_TICK: res.verdict = V_DONE;
      MODE_BLOCK: begin
        if (cur.source_ip == 32'd0) begin
          res.verdict = V_ZERO_ADDR;
        end else begin
          if (found) begin
            slot = fidx;
            slot_ok = 1'b1;
          end
          do_ins = slot_ok;
          full = !slot_ok;
        end
      end
      MODE_UNBLOCK: begin
        if (cur.source_ip == 32'd0) begin
          res.verdict = V_ZERO_ADDR;
        end else begin
          do_clr = found;
        end
      end
      default: res.verdict = V_DONE;
    endcase
    res.table_full = full;
    wr_en = fire && do_ins;
    wr_idx = slot;
    wr_data.addr = cur.source_ip;
    wr_data.start_ms = now_ms;
    wr_data.seconds = ins_secs;
  end

  // A refresh into the slot just cleared leaves it valid.
  always_comb begin
    valid_next = valid;
    if (do_clr) begin
      valid_next[fidx] = 1'b0;
    end
    if (do_ins) begin
      valid_next[slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      now_ms <= '0;
    end else if (fire) begin
      if (mode_t'(cur.mode) == MODE_TICK) begin
        now_ms <= now_ms + 32'd1;
      end
      valid <= valid_next;
    end
  end

endmodule

// ===== design/packet_verdict_with_timed_blocklist.sv =====
// Packet verdict engine with a timed blocklist of source addresses.
// Input items arrive on the s_ stream: s_tuser carries the mode (packet,
// one millisecond tick, block, unblock) and s_tdata the packet fields.
// Each input item gives exactly one result item on the m_ stream.
// Configuration registers are written through cfg_wen/cfg_addr/cfg_wdata;
// the user writes them only while the block is idle (the block does not
// enforce this); they take effect at once. A tick item goes to its result
// without a scan. Every other item scans the blocklist memory one entry per
// cycle through its one read port. One item is worked on at a time: the next
// item is taken only once the result of the last has gone to the output
// register.
// The result waits in an output register, and a stalled receiver holds that
// register and keeps s_tready low once the next item has finished. Reset
// clears all valid bits, the millisecond counter and the registers (auto
// block duration to 300 seconds); no clearing pass is needed, so items are
// taken right after reset.
module packet_verdict_with_timed_blocklist (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // source_ip[31:0], has_source[32], sig_matched[33], sig_severity[35:34],
  // block_seconds[51:36], zero fill [55:52]
  input  logic [55:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // drop[0], verdict[4:1], table_full[5], zero fill [7:6]
  output logic [7:0]  m_tdata,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import pvtb_pkg::*;

  cfg_t cfg;
  item_t item;
  result_t res, out_res;
  logic res_valid, res_ready;
  logic full_ok, drop_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled <= 1'b0;
      cfg.action <= '0;
      cfg.auto_block_seconds <= DEFAULT_BLOCK_SECONDS;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_ENABLED:         cfg.enabled <= cfg_wdata[0];
        REG_ACTION_LOW:      cfg.action[0] <= cfg_wdata[1:0];
        REG_ACTION_MEDIUM:   cfg.action[1] <= cfg_wdata[1:0];
        REG_ACTION_HIGH:     cfg.action[2] <= cfg_wdata[1:0];
        REG_ACTION_CRITICAL: cfg.action[3] <= cfg_wdata[1:0];
        REG_AUTO_BLOCK:      cfg.auto_block_seconds <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign item.mode = s_tuser;
  assign item.source_ip = s_tdata[31:0];
  assign item.has_source = s_tdata[32];
  assign item.sig_matched = s_tdata[33];
  assign item.sig_severity = s_tdata[35:34];
  assign item.block_seconds = s_tdata[51:36];

  pvtb_core u_core (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .item(item), .cfg(cfg),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.table_full, out_res.verdict, out_res.drop};

  assign full_ok = (m_tdata[4:1] == V_DROP_SIG) || (m_tdata[4:1] == V_REJECT_SIG) ||
                   (m_tdata[4:1] == V_DONE);
  assign drop_ok = (m_tdata[4:1] == V_DROP_BLOCKED) || (m_tdata[4:1] == V_DROP_SIG) ||
                   (m_tdata[4:1] == V_REJECT_SIG);

`include "packet_verdict_with_timed_blocklist_assert.svh"

  `PVTB_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)
  `PVTB_ASSERT_IMPLY(a_full_verdict, clk, rst, m_tvalid && m_tdata[5], full_ok)
  `PVTB_ASSERT_IMPLY(a_drop_verdict, clk, rst, m_tvalid && m_tdata[0], drop_ok)
  `PVTB_ASSERT_NEXT(a_result_taken, clk, rst, res_valid && res_ready, m_tvalid && s_tready)

endmodule
